/* sv/gsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Field widths, operation and status codes, transaction structs and the
// control and status structs of the version store.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int OP_W      = 2;
    localparam int HANDLE_W  = 11;
    localparam int VER_W     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STALE     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [HANDLE_W-1:0]  slot_handle;
        logic [VER_W-1:0]     handle_version;
        logic [PAYLOAD_W-1:0] payload_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [HANDLE_W-1:0]  handle_index_out;
        logic [VER_W-1:0]     version_out;
        logic [PAYLOAD_W-1:0] payload_out;
    } rsp_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clear;
    } vs_ctrl_t;

    typedef struct packed {
        logic ready;
        logic clear_done;
    } vs_stat_t;

endpackage
`default_nettype wire

/* sv/gsa_vstore.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Version store
// Synchronous version memory with a registered read. Zeroes every entry
// after reset and bumps every entry on a clear pass, one entry per cycle.
// ----------------------------------------------------------------------------
module gsa_vstore
    import gsa_pkg::*;
#(
    parameter int SLOT_COUNT = 1024
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire vs_ctrl_t                       ctrl,
    input  wire logic [$clog2(SLOT_COUNT)-1:0]  addr,
    input  wire logic [VER_W-1:0]               wdata,
    output      logic [VER_W-1:0]               rdata,
    output      vs_stat_t                       stat
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(SLOT_COUNT);

    localparam logic [1:0] M_INIT  = 2'd0;
    localparam logic [1:0] M_IDLE  = 2'd1;
    localparam logic [1:0] M_CLEAR = 2'd2;

    logic [VER_W-1:0] mem [SLOT_COUNT];

    logic [1:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wb_valid_reg, wb_valid_next;
    logic [IDX_W-1:0] wb_addr_reg, wb_addr_next;
    logic [VER_W-1:0] rdata_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [VER_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    always_comb
    begin
        mode_next     = mode_reg;
        cnt_next      = cnt_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr;
        mem_wdata     = wdata;
        mem_re        = 1'b0;
        mem_raddr     = addr;
        case (mode_reg)
            M_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[IDX_W-1:0];
                mem_wdata = '0;
                if (cnt_reg == LAST_CNT)
                begin
                    mode_next = M_IDLE;
                    cnt_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            M_IDLE:
            begin
                mem_we   = ctrl.wr;
                mem_re   = ctrl.rd;
                cnt_next = '0;
                if (ctrl.clear)
                begin
                    mode_next = M_CLEAR;
                end
            end
            M_CLEAR:
            begin
                if (cnt_reg != END_CNT)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + CNT_W'(1);
                    wb_valid_next = 1'b1;
                    wb_addr_next  = cnt_reg[IDX_W-1:0];
                end
                mem_we    = wb_valid_reg;
                mem_waddr = wb_addr_reg;
                mem_wdata = rdata_reg + VER_W'(1);
                if (wb_valid_reg && (cnt_reg == END_CNT))
                begin
                    mode_next = M_IDLE;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_INIT;
            cnt_reg      <= '0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            cnt_reg      <= cnt_next;
            wb_valid_reg <= wb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg <= wb_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign rdata           = rdata_reg;
    assign stat.ready      = (mode_reg == M_IDLE);
    assign stat.clear_done = (mode_reg == M_CLEAR) && wb_valid_reg && (cnt_reg == END_CNT);

endmodule
`default_nettype wire

/* sv/generational_slot_allocator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational slot allocator
// Slot map handing out handles of a one-based slot index and a 16-bit
// version; allocate, free, lookup and clear-all requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: present request and raise start; the transaction is
//   taken at the clock edge where start is high and busy is low.
//   Result channel: result_valid is high for exactly one cycle with the
//   result; there is no backpressure, so the receiver must take it then.
//   Path from acceptance to the result:
//     free, lookup, allocate of a fresh slot, table full : check state
//     allocate from the free stack                        : pop, then check
//     clear all                                           : clear until done
//   The next request may be taken in the cycle the result is shown. The
//   version memory read followed by the check and write-back sets the
//   path; a free-stack pop adds one more memory read.
//   Reset: busy stays high while the version memory is swept to zero;
//   counters clear at once.
// ----------------------------------------------------------------------------
module generational_slot_allocator_top
    import gsa_pkg::*;
#(
    parameter int SLOT_COUNT   = 1024,
    parameter int PAYLOAD_BITS = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t request,
    output      logic busy,
    output      logic result_valid,
    output      rsp_t result
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;

    localparam logic [CNT_W-1:0] END_CNT = CNT_W'(SLOT_COUNT);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [PAYLOAD_BITS-1:0] payload_mem [SLOT_COUNT];
    logic [IDX_W-1:0]        stack_mem   [SLOT_COUNT];

    logic [1:0]              state_reg, state_next;
    req_t                    req_reg, req_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic                    from_stack_reg, from_stack_next;
    logic                    full_reg, full_next;
    logic [CNT_W-1:0]        free_count_reg, free_count_next;
    logic [CNT_W-1:0]        fresh_reg, fresh_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    valid_reg, valid_next;
    logic [PAYLOAD_BITS-1:0] pay_rdata_reg;
    logic [IDX_W-1:0]        stack_rdata_reg;

    vs_ctrl_t                vs_ctrl;
    vs_stat_t                vs_stat;
    logic [IDX_W-1:0]        vs_addr;
    logic [VER_W-1:0]        vs_wdata;
    logic [VER_W-1:0]        vs_rdata;

    logic                    accept;
    logic [IDX_W-1:0]        handle_slot;
    logic [IDX_W-1:0]        stack_top;
    logic [HANDLE_W-1:0]     slot_plus1;
    logic                    bad_index;
    logic                    stale;
    logic                    pay_we, pay_re;
    logic                    stack_we, stack_re;

    gsa_vstore #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_vstore (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (vs_ctrl),
        .addr  (vs_addr),
        .wdata (vs_wdata),
        .rdata (vs_rdata),
        .stat  (vs_stat)
    );

    assign busy        = (state_reg != S_IDLE) || !vs_stat.ready;
    assign accept      = start && !busy;
    assign handle_slot = IDX_W'(request.slot_handle - HANDLE_W'(1));
    assign stack_top   = IDX_W'(free_count_reg - CNT_W'(1));
    assign slot_plus1  = HANDLE_W'(CNT_W'(slot_reg) + CNT_W'(1));
    assign bad_index   = (req_reg.slot_handle == '0)
                      || (CMP_W'(req_reg.slot_handle) > CMP_W'(fresh_reg));
    assign stale       = (vs_rdata != req_reg.handle_version);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        slot_next       = slot_reg;
        from_stack_next = from_stack_reg;
        full_next       = full_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        rsp_next        = rsp_reg;
        valid_next      = 1'b0;
        vs_ctrl         = '0;
        vs_addr         = slot_reg;
        vs_wdata        = vs_rdata + VER_W'(1);
        pay_we          = 1'b0;
        pay_re          = 1'b0;
        stack_we        = 1'b0;
        stack_re        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = request;
                    slot_next       = handle_slot;
                    from_stack_next = 1'b0;
                    full_next       = 1'b0;
                    case (request.op)
                        OP_ALLOC:
                        begin
                            if (free_count_reg != '0)
                            begin
                                stack_re        = 1'b1;
                                from_stack_next = 1'b1;
                                state_next      = S_POP;
                            end
                            else
                            begin
                                full_next  = (fresh_reg == END_CNT);
                                slot_next  = fresh_reg[IDX_W-1:0];
                                vs_ctrl.rd = 1'b1;
                                vs_addr    = fresh_reg[IDX_W-1:0];
                                state_next = S_CHECK;
                            end
                        end
                        OP_FREE, OP_LOOKUP:
                        begin
                            vs_ctrl.rd = 1'b1;
                            vs_addr    = handle_slot;
                            pay_re     = 1'b1;
                            state_next = S_CHECK;
                        end
                        OP_CLEAR:
                        begin
                            vs_ctrl.clear = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                slot_next  = stack_rdata_reg;
                vs_ctrl.rd = 1'b1;
                vs_addr    = stack_rdata_reg;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                valid_next                = 1'b1;
                state_next                = S_IDLE;
                rsp_next.status           = ST_OK;
                rsp_next.handle_index_out = req_reg.slot_handle;
                rsp_next.version_out      = '0;
                rsp_next.payload_out      = '0;
                case (req_reg.op)
                    OP_ALLOC:
                    begin
                        if (full_reg)
                        begin
                            rsp_next.status           = ST_FULL;
                            rsp_next.handle_index_out = '0;
                        end
                        else
                        begin
                            rsp_next.handle_index_out = slot_plus1;
                            rsp_next.version_out      = vs_rdata;
                            pay_we                    = 1'b1;
                            if (from_stack_reg)
                            begin
                                free_count_next = free_count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                fresh_next = fresh_reg + CNT_W'(1);
                            end
                        end
                    end
                    OP_FREE:
                    begin
                        if (bad_index)
                        begin
                            rsp_next.status = ST_BAD_INDEX;
                        end
                        else if (stale)
                        begin
                            rsp_next.status = ST_STALE;
                        end
                        else
                        begin
                            vs_ctrl.wr = 1'b1;
                            if (free_count_reg != END_CNT)
                            begin
                                stack_we        = 1'b1;
                                free_count_next = free_count_reg + CNT_W'(1);
                            end
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (bad_index)
                        begin
                            rsp_next.status = ST_BAD_INDEX;
                        end
                        else if (stale)
                        begin
                            rsp_next.status = ST_STALE;
                        end
                        else
                        begin
                            rsp_next.payload_out = PAYLOAD_W'(pay_rdata_reg);
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_OK;
                    end
                endcase
            end
            S_CLEAR:
            begin
                if (vs_stat.clear_done)
                begin
                    valid_next                = 1'b1;
                    state_next                = S_IDLE;
                    fresh_next                = '0;
                    free_count_next           = '0;
                    rsp_next.status           = ST_OK;
                    rsp_next.handle_index_out = req_reg.slot_handle;
                    rsp_next.version_out      = '0;
                    rsp_next.payload_out      = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            from_stack_reg <= 1'b0;
            full_reg       <= 1'b0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            from_stack_reg <= from_stack_next;
            full_reg       <= full_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        slot_reg <= slot_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            payload_mem[slot_reg] <= PAYLOAD_BITS'(req_reg.payload_in);
        end
        if (pay_re)
        begin
            pay_rdata_reg <= payload_mem[handle_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[free_count_reg[IDX_W-1:0]] <= slot_reg;
        end
        if (stack_re)
        begin
            stack_rdata_reg <= stack_mem[stack_top];
        end
    end

    assign result_valid = valid_reg;
    assign result       = rsp_reg;

endmodule
`default_nettype wire

/* sv/gsa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational slot allocator checker
// Port-level assertions on request acceptance and result transactions.
// ----------------------------------------------------------------------------
module gsa_checker
    import gsa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire req_t request,
    input wire logic busy,
    input wire logic result_valid,
    input wire rsp_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == ST_FULL)) |->
        ((result.handle_index_out == '0) && (result.version_out == '0)))
        else $error("table-full result carries a handle");

    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_OK)) |-> (result.payload_out == '0))
        else $error("failed transaction returned a payload");

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (.*);
`default_nettype wire

/* tb/generational_slot_allocator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator checker
// Watches the request and result channels, keeps its own slot map (versions,
// payloads, free stack, fresh pointer), predicts the result of every
// accepted transaction and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module generational_slot_allocator_checker
    import gsa_pkg::*;
#(
    parameter int SLOT_COUNT = 1024
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire req_t request,
    input  wire logic result_valid,
    input  wire rsp_t result,
    output int        fail_count,
    output int        pending
);

    logic [VER_W-1:0]     version_store [SLOT_COUNT];
    logic [PAYLOAD_W-1:0] payload_store [SLOT_COUNT];
    int unsigned          free_stack    [SLOT_COUNT];
    int unsigned          free_depth;
    int unsigned          next_fresh;
    rsp_t                 owed_results [$];

    task automatic report(input string what, input logic [63:0] want,
                          input logic [63:0] got);
        $display("%0t ns: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
        fail_count++;
    endtask

    function automatic rsp_t apply_request(input req_t r);
        rsp_t        o;
        int unsigned idx;
        int unsigned s;
        logic        got;
        o = '0;
        o.status = ST_OK;
        o.handle_index_out = r.slot_handle;
        idx = r.slot_handle;
        got = 1'b0;
        s = 0;
        case (r.op)
            OP_ALLOC:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    s = free_stack[free_depth] % SLOT_COUNT;
                    got = 1'b1;
                end
                else if (next_fresh < SLOT_COUNT)
                begin
                    s = next_fresh;
                    next_fresh++;
                    got = 1'b1;
                end
                if (got)
                begin
                    payload_store[s] = r.payload_in;
                    o.handle_index_out = HANDLE_W'(s + 1);
                    o.version_out = version_store[s];
                end
                else
                begin
                    o.status = ST_FULL;
                    o.handle_index_out = '0;
                end
            end
            OP_FREE, OP_LOOKUP:
            begin
                if (idx == 0 || idx > next_fresh)
                    o.status = ST_BAD_INDEX;
                else if (version_store[idx-1] != r.handle_version)
                    o.status = ST_STALE;
                else if (r.op == OP_LOOKUP)
                    o.payload_out = payload_store[idx-1];
                else
                begin
                    if (free_depth < SLOT_COUNT)
                    begin
                        free_stack[free_depth] = idx - 1;
                        free_depth++;
                    end
                    version_store[idx-1] = version_store[idx-1] + 1'b1;
                end
            end
            default:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    version_store[i] = version_store[i] + 1'b1;
                next_fresh = 0;
                free_depth = 0;
            end
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                version_store[i] = '0;
            free_depth = 0;
            next_fresh = 0;
            owed_results.delete();
            pending <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (owed_results.size() == 0)
                    report("unexpected result", '0, result);
                else
                begin
                    want = owed_results.pop_front();
                    if (result.status !== want.status)
                        report("status", want.status, result.status);
                    if (result.handle_index_out !== want.handle_index_out)
                        report("handle_index_out", want.handle_index_out,
                               result.handle_index_out);
                    if (result.version_out !== want.version_out)
                        report("version_out", want.version_out, result.version_out);
                    if (result.payload_out !== want.payload_out)
                        report("payload_out", want.payload_out, result.payload_out);
                end
            end
            if (start && !busy)
                owed_results.push_back(apply_request(request));
            pending <= owed_results.size();
        end
    end

endmodule

/* tb/generational_slot_allocator_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator testbench
// Drives directed and random allocate, free, lookup and clear transactions
// with random idle gaps, tracks live handles from the results and freed
// handles from its own frees to build well-formed and broken sequences, and
// gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module generational_slot_allocator_top_test;
    import gsa_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int CYCLE_CAP  = 500000;
    localparam int RAND_ITEMS = 950;

    typedef struct packed {
        logic [HANDLE_W-1:0] idx;
        logic [VER_W-1:0]    ver;
    } handle_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic result_valid;
    rsp_t result;
    int   fail_count;
    int   pending;
    int   cycles = 0;

    logic [OP_W-1:0] op_log [$];
    handle_t         live [$];
    handle_t         dead [$];
    int              calm_left = 0;
    logic            back_to_back = 1'b0;

    generational_slot_allocator_top #(
        .SLOT_COUNT   (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    generational_slot_allocator_checker #(
        .SLOT_COUNT (SLOTS)
    ) result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // harvest live handles from allocate results; a clear result empties the list
    always @(negedge clk)
    begin : track
        logic [OP_W-1:0] done_op;
        handle_t         h;
        if (rst_n && start && !busy)
            op_log.push_back(request.op);
        if (rst_n && result_valid && op_log.size() > 0)
        begin
            done_op = op_log.pop_front();
            if (done_op == OP_CLEAR)
                live.delete();
            else if (done_op == OP_ALLOC && result.status == ST_OK)
            begin
                h.idx = result.handle_index_out;
                h.ver = result.version_out;
                live.push_back(h);
            end
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] idx,
                        input logic [VER_W-1:0] ver, input logic [PAYLOAD_W-1:0] word);
        int   gap;
        req_t r;
        if (calm_left == 0)
        begin
            calm_left = $urandom_range(20, 80);
            back_to_back = ($urandom_range(0, 2) == 0);
        end
        calm_left--;
        gap = back_to_back ? 0 : $urandom_range(0, 19);
        r.op = op;
        r.slot_handle = idx;
        r.handle_version = ver;
        r.payload_in = word;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        handle_t h;
        int      k;
        int      roll;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_LOOKUP, 11'd0, 16'd0, 32'd0);
        send(OP_FREE, 11'd1, 16'd0, 32'd0);
        send(OP_ALLOC, 11'd0, 16'd0, 32'd0);
        send(OP_ALLOC, 11'd0, 16'd0, 32'hffff_ffff);
        send(OP_LOOKUP, 11'd1, 16'd0, 32'd0);
        send(OP_LOOKUP, 11'd2, 16'd0, 32'd0);
        send(OP_LOOKUP, 11'd2, 16'hffff, 32'd0);
        send(OP_FREE, 11'd1, 16'd0, 32'd0);
        send(OP_FREE, 11'd1, 16'd0, 32'd0);
        send(OP_LOOKUP, 11'd1, 16'd0, 32'd0);
        send(OP_ALLOC, 11'd0, 16'd0, 32'ha5a5_a5a5);
        send(OP_LOOKUP, 11'd1, 16'd1, 32'd0);
        send(OP_FREE, 11'd3, 16'd0, 32'd0);
        send(OP_LOOKUP, 11'h7ff, 16'hffff, 32'd0);
        send(OP_FREE, 11'd1024, 16'd0, 32'd0);
        send(OP_FREE, 11'd2, 16'd0, 32'd0);
        send(OP_FREE, 11'd1, 16'd1, 32'd0);
        send(OP_ALLOC, 11'd0, 16'd0, 32'h1234_5678);
        send(OP_ALLOC, 11'd0, 16'd0, 32'h8765_4321);
        send(OP_ALLOC, 11'd0, 16'd0, 32'h0f0f_0f0f);
        send(OP_CLEAR, 11'h7ff, 16'hffff, 32'hffff_ffff);
        send(OP_LOOKUP, 11'd1, 16'd2, 32'd0);
        send(OP_ALLOC, 11'd0, 16'd0, 32'h5a5a_5a5a);

        // fill the table past full
        send(OP_CLEAR, 11'd0, 16'd0, 32'd0);
        for (int n = 0; n < SLOTS + 4; n++)
            send(OP_ALLOC, HANDLE_W'($urandom_range(0, 2047)), VER_W'($urandom), $urandom);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send(OP_CLEAR, HANDLE_W'($urandom_range(0, 2047)), VER_W'($urandom),
                     $urandom);
            else if (roll < 12)
            begin
                h.idx = HANDLE_W'($urandom_range(0, 2047));
                h.ver = VER_W'($urandom);
                if (dead.size() > 0 && $urandom_range(0, 1) == 1)
                    h = dead[$urandom_range(0, dead.size() - 1)];
                else if (live.size() > 0 && $urandom_range(0, 1) == 1)
                begin
                    h = live[$urandom_range(0, live.size() - 1)];
                    h.ver = h.ver ^ VER_W'($urandom_range(1, 65535));
                end
                send($urandom_range(0, 1) == 1 ? OP_FREE : OP_LOOKUP, h.idx, h.ver,
                     $urandom);
            end
            else if (roll < 45 || live.size() == 0)
                send(OP_ALLOC, HANDLE_W'($urandom_range(0, 2047)), VER_W'($urandom),
                     $urandom);
            else if (roll < 72)
            begin
                k = $urandom_range(0, live.size() - 1);
                h = live[k];
                live.delete(k);
                if (dead.size() >= 64)
                    void'(dead.pop_front());
                dead.push_back(h);
                send(OP_FREE, h.idx, h.ver, $urandom);
            end
            else
            begin
                h = live[$urandom_range(0, live.size() - 1)];
                send(OP_LOOKUP, h.idx, h.ver, $urandom);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
